>>> design/lpps_pkg.sv
// Shared types, constants and helpers for the list push/pop/search block.
package lpps_pkg;

  localparam int DEPTH   = 32;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int RES_CAP = 32;
  localparam int MCNT_W  = $clog2(RES_CAP + 1);

  localparam logic [1:0] FUNC_PUSH   = 2'd0;
  localparam logic [1:0] FUNC_POP    = 2'd1;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [2:0] ST_DONE  = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_MATCH = 3'd3;
  localparam logic [2:0] ST_NONE  = 3'd4;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [4:0]         position;
    logic signed [31:0] found_value;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } cmd_t;

  function automatic logic [4:0] pos_field(input logic [CNT_W-1:0] p);
    logic [31:0] t;
    t = 32'(p);
    return t[4:0];
  endfunction

endpackage

>>> design/list_push_front_pop_back_search.sv
// Top level of the bounded list with push-front, pop-back and search.
//
//   channel  ports                        word        direction
//   in       in_valid in_ready in_data    in_word_t   into block
//   out      out_valid out_ready out_data out_word_t  out of block
//
// Push, pop and unused codes are completed in the back end's idle state once queued.
// Search steps in the back end: accept, one entry read per cycle (held while a match
// waits for the result register), a compare of the last read, and the final result.
// A second match, the final result and a new command wait for a free result register.
// A two-word command queue lets input words be taken while the back end works.
// Reset (rst_n low, synchronous) empties the list; entry memory is not cleared.
module list_push_front_pop_back_search
  import lpps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  lpps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  lpps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> design/lpps_front.sv
// Front end: accepts input words, decodes the operation and queues commands.
module lpps_front
  import lpps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  output logic     q_valid,
  input  logic     q_ready,
  output cmd_t     q_cmd
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       cmd;

  always_comb begin
    cmd.value = in_data.value;
    case (in_data.func)
      FUNC_PUSH:   cmd.op = OP_PUSH;
      FUNC_POP:    cmd.op = OP_POP;
      FUNC_SEARCH: cmd.op = OP_SEARCH;
      default:     cmd.op = OP_NOP;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

>>> design/lpps_back.sv
// Back end: list state, entry memory, search scan and result register.
module lpps_back
  import lpps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_ready,
  input  cmd_t      q_cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [31:0] mem [DEPTH];

  logic [1:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   front_r, front_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic [CNT_W-1:0]   issue_r, issue_nxt;
  logic               cmp_v_r, cmp_v_nxt;
  logic [CNT_W-1:0]   cmp_pos_r, cmp_pos_nxt;
  logic signed [31:0] rd_data_r;
  logic               pend_v_r, pend_v_nxt;
  logic [CNT_W-1:0]   pend_pos_r, pend_pos_nxt;
  logic signed [31:0] pend_val_r, pend_val_nxt;
  logic [MCNT_W-1:0]  mcnt_r, mcnt_nxt;
  logic               cap_r, cap_nxt;
  logic               out_v_r;
  out_word_t          out_r;

  logic             out_free, load_out, mem_we, rd_en;
  logic             hit, stall, cap_hit;
  out_word_t        out_word;
  logic [IDX_W-1:0] dec_front, rd_addr;
  logic [IDX_W:0]   addr_sum;

  assign out_free  = !out_v_r || out_ready;
  assign dec_front = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - 1'b1;
  assign addr_sum  = {1'b0, front_r} + {1'b0, issue_r[IDX_W-1:0]};
  assign rd_addr   = (addr_sum >= (IDX_W+1)'(DEPTH)) ?
                     IDX_W'(addr_sum - (IDX_W+1)'(DEPTH)) : addr_sum[IDX_W-1:0];
  assign hit       = cmp_v_r && (rd_data_r == key_r);
  assign stall     = hit && pend_v_r && !out_free;
  assign cap_hit   = hit && (mcnt_r == MCNT_W'(RES_CAP - 1));

  always_comb begin
    state_nxt    = state_r;
    front_nxt    = front_r;
    count_nxt    = count_r;
    key_nxt      = key_r;
    issue_nxt    = issue_r;
    cmp_v_nxt    = cmp_v_r;
    cmp_pos_nxt  = cmp_pos_r;
    pend_v_nxt   = pend_v_r;
    pend_pos_nxt = pend_pos_r;
    pend_val_nxt = pend_val_r;
    mcnt_nxt     = mcnt_r;
    cap_nxt      = cap_r;
    q_ready      = 1'b0;
    load_out     = 1'b0;
    mem_we       = 1'b0;
    rd_en        = 1'b0;
    out_word     = '0;
    out_word.last = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_ready = 1'b1;
          case (q_cmd.op)
            OP_PUSH: begin
              load_out = 1'b1;
              if (count_r == CNT_W'(DEPTH)) begin
                out_word.status = ST_FULL;
              end else begin
                out_word.status = ST_DONE;
                front_nxt = dec_front;
                count_nxt = count_r + 1'b1;
                mem_we    = 1'b1;
              end
            end
            OP_POP: begin
              load_out = 1'b1;
              if (count_r == '0) begin
                out_word.status = ST_EMPTY;
              end else begin
                out_word.status = ST_DONE;
                count_nxt = count_r - 1'b1;
              end
            end
            OP_SEARCH: begin
              if (count_r == '0) begin
                load_out = 1'b1;
                out_word.status = ST_EMPTY;
              end else begin
                state_nxt  = S_SCAN;
                key_nxt    = q_cmd.value;
                issue_nxt  = '0;
                cmp_v_nxt  = 1'b0;
                pend_v_nxt = 1'b0;
                mcnt_nxt   = '0;
                cap_nxt    = 1'b0;
              end
            end
            default: begin
              load_out = 1'b1;
              out_word.status = ST_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!stall) begin
          if (hit) begin
            if (pend_v_r) begin
              load_out             = 1'b1;
              out_word.status      = ST_MATCH;
              out_word.position    = pos_field(pend_pos_r);
              out_word.found_value = pend_val_r;
              out_word.last        = 1'b0;
            end
            pend_v_nxt   = 1'b1;
            pend_pos_nxt = cmp_pos_r;
            pend_val_nxt = rd_data_r;
            mcnt_nxt     = mcnt_r + 1'b1;
            if (cap_hit) begin
              cap_nxt = 1'b1;
            end
          end
          if ((issue_r < count_r) && !cap_r && !cap_hit) begin
            rd_en       = 1'b1;
            cmp_v_nxt   = 1'b1;
            cmp_pos_nxt = issue_r;
            issue_nxt   = issue_r + 1'b1;
          end else begin
            cmp_v_nxt = 1'b0;
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          load_out = 1'b1;
          if (pend_v_r) begin
            out_word.status      = ST_MATCH;
            out_word.position    = pos_field(pend_pos_r);
            out_word.found_value = pend_val_r;
          end else begin
            out_word.status = ST_NONE;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      front_r  <= '0;
      count_r  <= '0;
      cmp_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      cap_r    <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      front_r  <= front_nxt;
      count_r  <= count_nxt;
      cmp_v_r  <= cmp_v_nxt;
      pend_v_r <= pend_v_nxt;
      cap_r    <= cap_nxt;
      if (load_out) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    issue_r    <= issue_nxt;
    cmp_pos_r  <= cmp_pos_nxt;
    pend_pos_r <= pend_pos_nxt;
    pend_val_r <= pend_val_nxt;
    mcnt_r     <= mcnt_nxt;
    if (load_out) begin
      out_r <= out_word;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[dec_front] <= q_cmd.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
